[design/mts_pkg.sv]
// Package for the multiplexed timer slot bank: operation codes, control states,
// head-of-ring control/status structs and stream packing constants.
// No dependencies.
package mts_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    op_t  op;
    logic hit;
  } head_ctl_t;

  typedef struct packed {
    logic fire;
    logic fire_rep;
  } head_stat_t;

  localparam int IDX_W       = 3;
  localparam int PERIOD_W    = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  localparam int IN_IDX_LSB  = 0;
  localparam int IN_PER_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_MODE_BIT = IN_PER_LSB + PERIOD_W;

endpackage

[design/mts_cell.sv]
// One cell of the slot ring: holds a slot record and passes it to its
// neighbor when the ring advances. Flags a slot that expires on the next tick.
// No package dependencies.
module mts_cell #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  d_running,
  input  logic                  d_repeating,
  input  logic [COUNT_BITS-1:0] d_remaining,
  input  logic [COUNT_BITS-1:0] d_period,
  output logic                  q_running,
  output logic                  q_repeating,
  output logic [COUNT_BITS-1:0] q_remaining,
  output logic [COUNT_BITS-1:0] q_period,
  output logic                  q_expiring
);

  logic                  running_r;
  logic                  repeating_r;
  logic [COUNT_BITS-1:0] remaining_r;
  logic [COUNT_BITS-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      repeating_r <= 1'b0;
      remaining_r <= '0;
      period_r    <= '0;
    end else if (shift_en) begin
      running_r   <= d_running;
      repeating_r <= d_repeating;
      remaining_r <= d_remaining;
      period_r    <= d_period;
    end
  end

  assign q_running   = running_r;
  assign q_repeating = repeating_r;
  assign q_remaining = remaining_r;
  assign q_period    = period_r;
  assign q_expiring  = running_r && (remaining_r[COUNT_BITS-1:1] == '0);

endmodule

[design/mts_head.sv]
// Update unit at the head of the slot ring: applies a tick or a command to
// the slot record passing by. Depends on mts_pkg.
module mts_head import mts_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  head_ctl_t             ctl,
  input  logic [COUNT_BITS-1:0] in_period,
  input  logic                  in_repeating,
  input  logic                  cur_running,
  input  logic                  cur_repeating,
  input  logic [COUNT_BITS-1:0] cur_remaining,
  input  logic [COUNT_BITS-1:0] cur_period,
  output logic                  nxt_running,
  output logic                  nxt_repeating,
  output logic [COUNT_BITS-1:0] nxt_remaining,
  output logic [COUNT_BITS-1:0] nxt_period,
  output head_stat_t            stat
);

  always_comb begin
    logic reload;
    reload        = cur_repeating && (cur_period != '0);
    nxt_running   = cur_running;
    nxt_repeating = cur_repeating;
    nxt_remaining = cur_remaining;
    nxt_period    = cur_period;
    stat          = '0;
    case (ctl.op)
      OP_TICK: begin
        if (cur_running) begin
          if (cur_remaining[COUNT_BITS-1:1] != '0) begin
            nxt_remaining = cur_remaining - COUNT_BITS'(1);
          end else begin
            stat.fire     = 1'b1;
            stat.fire_rep = reload;
            if (reload) begin
              nxt_remaining = cur_period;
            end else begin
              nxt_running   = 1'b0;
              nxt_remaining = '0;
            end
          end
        end
      end
      OP_SET: begin
        if (ctl.hit) begin
          nxt_period    = in_period;
          nxt_repeating = in_repeating;
          if (cur_running) begin
            nxt_running   = (in_period != '0);
            nxt_remaining = in_period;
          end
        end
      end
      OP_START: begin
        if (ctl.hit) begin
          nxt_running   = (cur_period != '0);
          nxt_remaining = cur_period;
        end
      end
      OP_STOP: begin
        if (ctl.hit) begin
          nxt_running   = 1'b0;
          nxt_remaining = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/multiplexed_timer_slots.sv]
// Top level of the multiplexed timer slot bank: a ring of slot cells, the
// head update unit, sequencing control and the result register.
// Depends on mts_pkg, mts_cell and mts_head.
//
// Each input transfer (tick or command) is worked on while every slot record
// rotates once through the update unit at the head of the ring; the block
// then returns to idle and takes no new transfer before that. A tick yields
// one result per expiring slot in ascending slot order with tlast on the final
// one; the ring holds while a result cannot be placed in the output register.
// A result waiting on the output does not block the next input transfer.
module multiplexed_timer_slots import mts_pkg::*; #(
  parameter int TIMER_SLOTS = 8,
  parameter int COUNT_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] timer_index, [34:3] period, [35] mode, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] fired_timer, [3] fired_repeating, [7:4] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int SW = $clog2(TIMER_SLOTS);
  localparam int CW = (SW > IDX_W) ? SW : IDX_W;

  state_t                state_r, state_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [TIMER_SLOTS-1:0] fire_r, fire_nxt;
  op_t                   op_r, op_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] per_r, per_nxt;
  logic                  rep_r, rep_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_timer_r, out_timer_nxt;
  logic                  out_rep_r, out_rep_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  advance;
  logic                  last_step;
  logic                  is_last_fire;

  logic                  run_q  [TIMER_SLOTS];
  logic                  rpt_q  [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] rem_q  [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] per_q  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] exp_vec;

  logic                  h_running, h_repeating;
  logic [COUNT_BITS-1:0] h_remaining, h_period;
  head_ctl_t             h_ctl;
  head_stat_t            h_stat;

  for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_ring
    logic                  d_run, d_rpt;
    logic [COUNT_BITS-1:0] d_rem, d_per;
    if (k == TIMER_SLOTS - 1) begin : g_tail
      assign d_run = h_running;
      assign d_rpt = h_repeating;
      assign d_rem = h_remaining;
      assign d_per = h_period;
    end else begin : g_mid
      assign d_run = run_q[k+1];
      assign d_rpt = rpt_q[k+1];
      assign d_rem = rem_q[k+1];
      assign d_per = per_q[k+1];
    end
    mts_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (advance),
      .d_running  (d_run),
      .d_repeating(d_rpt),
      .d_remaining(d_rem),
      .d_period   (d_per),
      .q_running  (run_q[k]),
      .q_repeating(rpt_q[k]),
      .q_remaining(rem_q[k]),
      .q_period   (per_q[k]),
      .q_expiring (exp_vec[k])
    );
  end

  assign h_ctl.op  = op_r;
  assign h_ctl.hit = (CW'(step_r) == CW'(idx_r));

  mts_head #(.COUNT_BITS(COUNT_BITS)) u_head (
    .ctl          (h_ctl),
    .in_period    (per_r),
    .in_repeating (rep_r),
    .cur_running  (run_q[0]),
    .cur_repeating(rpt_q[0]),
    .cur_remaining(rem_q[0]),
    .cur_period   (per_q[0]),
    .nxt_running  (h_running),
    .nxt_repeating(h_repeating),
    .nxt_remaining(h_remaining),
    .nxt_period   (h_period),
    .stat         (h_stat)
  );

  assign last_step    = (step_r == SW'(TIMER_SLOTS - 1));
  assign is_last_fire = ((fire_r >> 1) == '0);

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    accept    = in_tvalid && in_tready;
    advance   = (state_r == ST_RUN) && (!h_stat.fire || !out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (advance && last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    step_nxt      = step_r;
    fire_nxt      = fire_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    per_nxt       = per_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r;
    out_timer_nxt = out_timer_r;
    out_rep_nxt   = out_rep_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (accept) begin
      step_nxt = '0;
      op_nxt   = op_t'(in_tuser[1:0]);
      idx_nxt  = in_tdata[IN_IDX_LSB +: IDX_W];
      per_nxt  = COUNT_BITS'(in_tdata[IN_PER_LSB +: PERIOD_W]);
      rep_nxt  = in_tdata[IN_MODE_BIT];
      fire_nxt = (op_t'(in_tuser[1:0]) == OP_TICK) ? exp_vec : '0;
    end else if (advance) begin
      step_nxt = last_step ? '0 : step_r + SW'(1);
      fire_nxt = fire_r >> 1;
      if (h_stat.fire) begin
        out_valid_nxt = 1'b1;
        out_timer_nxt = IDX_W'(step_r);
        out_rep_nxt   = h_stat.fire_rep;
        out_last_nxt  = is_last_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      fire_r      <= '0;
      op_r        <= OP_TICK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fire_r      <= fire_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    per_r       <= per_nxt;
    rep_r       <= rep_nxt;
    out_timer_r <= out_timer_nxt;
    out_rep_r   <= out_rep_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, out_rep_r, out_timer_r};
  assign out_tlast  = out_last_r;

endmodule

[design/mts_chk.sv]
// Port-level checker for multiplexed_timer_slots, attached by bind.
// Depends on mts_pkg.
module mts_chk import mts_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset leaves the block idle with no result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transfer taken while busy");

  // a command never produces a result
  a_cmd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != OP_TICK) && !out_tvalid |=> !out_tvalid)
    else $error("result after command");

endmodule

bind multiplexed_timer_slots mts_chk u_mts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

[verif/multiplexed_timer_slots_tb.sv]
`timescale 1ns / 1ps
// Testbench for multiplexed_timer_slots: directed command/tick table, then random traffic
// checked against an in-bench model of the slot bank. Depends on mts_pkg and the RTL top.
module multiplexed_timer_slots_tb;
  import mts_pkg::*;

  localparam int SLOTS = 8;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_ONE
  } row_chk_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  idx;
    logic [31:0] period;
    logic        mode;
    row_chk_t    chk;
    logic [2:0]  exp_timer;
    logic        exp_rep;
  } plan_row_t;

  typedef struct packed {
    logic [2:0] timer;
    logic       rep;
    logic       last;
  } expiry_t;

  localparam int PLAN_LEN = 26;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_STOP,  3'd3, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_SET,   3'd7, 32'd1,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd7, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_ONE,   3'd7, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_SET,   3'd0, 32'd1,         1'b1, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_ONE,   3'd0, 1'b1},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_ONE,   3'd0, 1'b1},
    '{OP_SET,   3'd0, 32'd0,         1'b1, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_SET,   3'd2, 32'hFFFF_FFFF, 1'b1, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd2, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_SET,   3'd5, 32'd2,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd5, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_START, 3'd5, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_QUIET, 3'd0, 1'b0},
    '{OP_TICK,  3'd0, 32'd0,         1'b0, CHK_ONE,   3'd5, 1'b0},
    '{OP_SET,   3'd1, 32'd1,         1'b1, CHK_MODEL, 3'd0, 1'b0},
    '{OP_START, 3'd1, 32'd0,         1'b0, CHK_MODEL, 3'd0, 1'b0},
    '{OP_TICK,  3'd6, 32'hFFFF_FFFF, 1'b1, CHK_MODEL, 3'd0, 1'b0},
    '{OP_STOP,  3'd2, 32'd0,         1'b0, CHK_MODEL, 3'd0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic        slot_on   [SLOTS];
  logic [31:0] slot_left [SLOTS];
  logic [31:0] slot_per  [SLOTS];
  logic        slot_rep  [SLOTS];

  expiry_t tick_fired [$];
  expiry_t expiry_q [$];
  int      errors = 0;
  bit      steady = 1'b0;
  int      hold_left = 0;
  int      ready_roll;

  multiplexed_timer_slots u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("multiplexed_timer_slots_tb NOT OK");
    $finish;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic arm_slot(input logic [2:0] s);
    if (slot_per[s] == 32'd0) begin
      slot_on[s]   = 1'b0;
      slot_left[s] = 32'd0;
    end else begin
      slot_on[s]   = 1'b1;
      slot_left[s] = slot_per[s];
    end
  endtask

  // Applies one transfer to the bank model; tick expiries land in tick_fired.
  task automatic step_bank(input op_t op, input logic [2:0] idx, input logic [31:0] period,
                           input logic mode);
    expiry_t e;
    tick_fired.delete();
    case (op)
      OP_SET: begin
        slot_per[idx] = period;
        slot_rep[idx] = mode;
        if (slot_on[idx]) arm_slot(idx);
      end
      OP_START: arm_slot(idx);
      OP_STOP: begin
        slot_on[idx]   = 1'b0;
        slot_left[idx] = 32'd0;
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_on[s]) continue;
          if (slot_left[s] > 32'd1) begin
            slot_left[s]--;
            continue;
          end
          if (slot_rep[s] && slot_per[s] != 32'd0) begin
            slot_left[s] = slot_per[s];
          end else begin
            slot_on[s]   = 1'b0;
            slot_left[s] = 32'd0;
          end
          e.timer = 3'(s);
          e.rep   = slot_on[s];
          e.last  = 1'b0;
          tick_fired.push_back(e);
        end
        if (tick_fired.size() > 0) begin
          e = tick_fired.pop_back();
          e.last = 1'b1;
          tick_fired.push_back(e);
        end
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(input op_t op, input logic [2:0] idx, input logic [31:0] period,
                           input logic mode, input row_chk_t chk,
                           input logic [2:0] exp_timer, input logic exp_rep);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, mode, period, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_bank(op, idx, period, mode);
    if (chk == CHK_MODEL) begin
      foreach (tick_fired[i]) expiry_q.push_back(tick_fired[i]);
    end else if (chk == CHK_ONE) begin
      expiry_q.push_back('{exp_timer, exp_rep, 1'b1});
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (steady || ready_roll < 60) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold_left = (ready_roll < 94) ? $urandom_range(0, 2) : $urandom_range(8, 20);
      end
    end
  end

  always @(posedge clk) begin
    expiry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expiry_q.size() == 0) begin
        note_error($sformatf("unexpected expiry: timer %0d rep %0d last %0d",
                             out_tdata[2:0], out_tdata[3], out_tlast));
      end else begin
        want = expiry_q.pop_front();
        if (out_tdata[2:0] !== want.timer || out_tdata[3] !== want.rep ||
            out_tlast !== want.last) begin
          note_error($sformatf("expiry mismatch: exp timer %0d rep %0d last %0d, got %0d %0d %0d",
                               want.timer, want.rep, want.last,
                               out_tdata[2:0], out_tdata[3], out_tlast));
        end
      end
    end
  end

  initial begin
    int   sent;
    int   r;
    op_t  op;
    logic [31:0] period;
    for (int s = 0; s < SLOTS; s++) begin
      slot_on[s]   = 1'b0;
      slot_left[s] = 32'd0;
      slot_per[s]  = 32'd0;
      slot_rep[s]  = 1'b0;
    end
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_item(PLAN[i].op, PLAN[i].idx, PLAN[i].period, PLAN[i].mode, PLAN[i].chk,
                PLAN[i].exp_timer, PLAN[i].exp_rep);
    end

    while (sent < 160 - PLAN_LEN) begin
      steady = (sent % 50) < 12;
      if ($urandom_range(0, 11) == 0) begin
        // arm every slot with a short period so one tick can fire all of them
        for (int s = 0; s < SLOTS; s++) begin
          send_item(OP_SET, 3'(s), 32'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                    CHK_MODEL, 3'd0, 1'b0);
          send_item(OP_START, 3'(s), 32'($urandom), 1'($urandom_range(0, 1)),
                    CHK_MODEL, 3'd0, 1'b0);
        end
        sent += 2 * SLOTS;
      end else begin
        r  = $urandom_range(0, 99);
        op = (r < 45) ? OP_TICK : (r < 65) ? OP_SET : (r < 88) ? OP_START : OP_STOP;
        r  = $urandom_range(0, 99);
        if (r < 70)      period = $urandom_range(1, 6);
        else if (r < 80) period = 32'd0;
        else if (r < 92) period = $urandom;
        else             period = 32'hFFFF_FFFF;
        send_item(op, 3'($urandom_range(0, 7)), period, 1'($urandom_range(0, 1)),
                  CHK_MODEL, 3'd0, 1'b0);
        sent++;
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (expiry_q.size() != 0) @(posedge clk);
    repeat (4 * SLOTS + 4) @(posedge clk);
    if (errors == 0) begin
      $display("multiplexed_timer_slots_tb OK");
    end else begin
      $display("multiplexed_timer_slots_tb NOT OK");
    end
    $finish;
  end

endmodule
